@@ hw/rtl/cst_pkg.sv @@
`default_nettype none
package cst_pkg;

    // Command codes carried in the request kind.
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_FWD   = 2'd1;
    localparam logic [1:0] CMD_BWD   = 2'd2;
    localparam logic [1:0] CMD_RDCLR = 2'd3;

    // Configuration register indexes.
    localparam logic REG_PLANE_SIZE    = 1'b0;
    localparam logic REG_CHANNEL_COUNT = 1'b1;

    localparam int MAX_CHANNELS_DEF = 256;
    localparam int CFG_W            = 17;

    // Queue between front and back: 2**QUEUE_AW entries.
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    // Classified request handed from front to back.
    typedef struct packed {
        logic [1:0]          cmd;
        logic [7:0]          chan;
        logic                in_range;
        logic signed [15:0]  x;
        logic signed [15:0]  g;
    } item_t;

    // Result fields of one delivered request.
    typedef struct packed {
        logic signed [15:0]  result;
        logic                active;
        logic signed [31:0]  grad_total;
        logic [7:0]          channel_out;
    } res_t;

endpackage
`default_nettype wire

@@ hw/rtl/cst_front.sv @@
`default_nettype none
module cst_front #(
    parameter int MAX_CHANNELS = cst_pkg::MAX_CHANNELS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic                        cfg_index,
    input  wire logic [cst_pkg::CFG_W-1:0]   cfg_wdata,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [1:0]                  in_cmd,
    input  wire logic                        in_restart,
    input  wire logic [7:0]                  in_sel,
    input  wire logic signed [15:0]          in_x,
    input  wire logic signed [15:0]          in_g,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output cst_pkg::item_t                   out_item
);

    localparam int LIM = (MAX_CHANNELS < 256) ? MAX_CHANNELS : 256;
    localparam logic [8:0] LIM_W = 9'(LIM);

    logic [16:0] plane_size_reg;
    logic [8:0]  channel_count_reg;
    logic [15:0] plane_pos_reg, plane_pos_next;
    logic [7:0]  cur_chan_reg, cur_chan_next;

    logic [16:0] ps_eff;
    logic [8:0]  cc_eff;
    logic [15:0] pos_base;
    logic [7:0]  chan_base;
    logic [16:0] pos_inc;
    logic [8:0]  chan_inc;
    logic        is_elem;
    logic        accept;

    assign in_ready  = out_ready;
    assign out_valid = in_valid;
    assign accept    = in_valid && out_ready;
    assign is_elem   = (in_cmd == cst_pkg::CMD_FWD) || (in_cmd == cst_pkg::CMD_BWD);

    always_comb begin
        ps_eff = plane_size_reg;
        if (plane_size_reg == 17'd0) begin
            ps_eff = 17'd1;
        end else if (plane_size_reg > 17'd65536) begin
            ps_eff = 17'd65536;
        end
        cc_eff = channel_count_reg;
        if (channel_count_reg == 9'd0) begin
            cc_eff = 9'd1;
        end else if (channel_count_reg > LIM_W) begin
            cc_eff = LIM_W;
        end
    end

    always_comb begin
        pos_base  = in_restart ? 16'd0 : plane_pos_reg;
        chan_base = in_restart ? 8'd0 : cur_chan_reg;
        pos_inc   = {1'b0, pos_base} + 17'd1;
        chan_inc  = {1'b0, chan_base} + 9'd1;
        if (pos_inc >= ps_eff) begin
            plane_pos_next = 16'd0;
            cur_chan_next  = (chan_inc >= cc_eff) ? 8'd0 : chan_inc[7:0];
        end else begin
            plane_pos_next = pos_inc[15:0];
            cur_chan_next  = chan_base;
        end
    end

    always_comb begin
        out_item.cmd = in_cmd;
        out_item.x   = in_x;
        out_item.g   = in_g;
        if (is_elem) begin
            out_item.chan     = chan_base;
            out_item.in_range = 1'b1;
        end else begin
            out_item.chan     = in_sel;
            out_item.in_range = ({1'b0, in_sel} < LIM_W);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_size_reg    <= 17'd1;
            channel_count_reg <= 9'd1;
            plane_pos_reg     <= 16'd0;
            cur_chan_reg      <= 8'd0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    cst_pkg::REG_PLANE_SIZE:    plane_size_reg    <= cfg_wdata;
                    cst_pkg::REG_CHANNEL_COUNT: channel_count_reg <= cfg_wdata[8:0];
                    default: ;
                endcase
            end
            if (accept && is_elem) begin
                plane_pos_reg <= plane_pos_next;
                cur_chan_reg  <= cur_chan_next;
            end
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/cst_queue.sv @@
`default_nettype none
module cst_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire cst_pkg::item_t   push_item,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output cst_pkg::item_t        pop_item
);

    cst_pkg::item_t                   q_mem [cst_pkg::QUEUE_DEPTH];
    logic [cst_pkg::QUEUE_AW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [cst_pkg::QUEUE_AW:0]       count_reg;
    logic                             push, pop;

    assign push_ready = (count_reg != (cst_pkg::QUEUE_AW + 1)'(cst_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = q_mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/cst_back.sv @@
`default_nettype none
module cst_back #(
    parameter int MAX_CHANNELS = cst_pkg::MAX_CHANNELS_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire cst_pkg::item_t   in_item,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output cst_pkg::res_t         out_res
);

    localparam int DEPTH  = (MAX_CHANNELS < 256) ? MAX_CHANNELS : 256;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic signed [15:0] thr_mem [DEPTH];
    logic signed [31:0] acc_mem [DEPTH];
    logic [DEPTH-1:0]   acc_vld_reg;

    // Execute stage
    logic               b2_valid_reg;
    cst_pkg::item_t     b2_item_reg;
    logic signed [15:0] thr_rd_reg;
    logic signed [31:0] acc_rd_reg;
    logic               acc_vld_rd_reg;
    logic               thr_fwd_reg, acc_fwd_reg;
    logic signed [15:0] thr_fwd_val_reg;
    logic signed [31:0] acc_fwd_val_reg;

    // Output register
    logic               out_valid_reg;
    cst_pkg::res_t      out_res_reg;

    logic               out_free, b2_fire, rd_en;
    logic [ADDR_W-1:0]  raddr, waddr;
    logic signed [15:0] t, x, g;
    logic signed [31:0] acc;
    logic signed [16:0] x_ext, neg_t, diff, sum;
    logic signed [32:0] acc_ext, g_ext, acc_sum;
    logic               br_pos, br_neg;
    logic signed [15:0] shrunk;
    logic signed [31:0] acc_new;
    logic               thr_we, acc_we;
    logic signed [31:0] acc_wval;
    cst_pkg::res_t      res;

    assign out_free = !out_valid_reg || out_ready;
    assign b2_fire  = b2_valid_reg && out_free;
    assign in_ready = !b2_valid_reg || b2_fire;
    assign rd_en    = in_valid && in_ready;
    assign raddr    = in_item.chan[ADDR_W-1:0];
    assign waddr    = b2_item_reg.chan[ADDR_W-1:0];

    // Take the value just written when the next request read the same entry.
    assign t   = thr_fwd_reg ? thr_fwd_val_reg : thr_rd_reg;
    assign acc = acc_fwd_reg ? acc_fwd_val_reg : (acc_vld_rd_reg ? acc_rd_reg : 32'sd0);
    assign x   = b2_item_reg.x;
    assign g   = b2_item_reg.g;

    always_comb begin
        x_ext   = {x[15], x};
        neg_t   = 17'sd0 - $signed({t[15], t});
        br_pos  = (x > t);
        br_neg  = !br_pos && (x_ext < neg_t);
        diff    = x_ext - $signed({t[15], t});
        sum     = x_ext + $signed({t[15], t});
        shrunk  = 16'sd0;
        if (br_pos) begin
            shrunk = (diff[16] != diff[15]) ? (diff[16] ? 16'sh8000 : 16'sh7fff)
                                            : diff[15:0];
        end else if (br_neg) begin
            shrunk = (sum[16] != sum[15]) ? (sum[16] ? 16'sh8000 : 16'sh7fff)
                                          : sum[15:0];
        end
        acc_ext = {acc[31], acc};
        g_ext   = {{17{g[15]}}, g};
        acc_sum = br_pos ? (acc_ext - g_ext) : (acc_ext + g_ext);
        acc_new = (acc_sum[32] != acc_sum[31])
                  ? (acc_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff) : acc_sum[31:0];
    end

    always_comb begin
        thr_we   = 1'b0;
        acc_we   = 1'b0;
        acc_wval = acc_new;
        res.result      = 16'sd0;
        res.active      = 1'b0;
        res.grad_total  = 32'sd0;
        res.channel_out = b2_item_reg.chan;
        case (b2_item_reg.cmd)
            cst_pkg::CMD_LOAD: begin
                thr_we = b2_fire && b2_item_reg.in_range;
            end
            cst_pkg::CMD_FWD: begin
                res.result = shrunk;
                res.active = br_pos || br_neg;
            end
            cst_pkg::CMD_BWD: begin
                res.result = (br_pos || br_neg) ? g : 16'sd0;
                res.active = br_pos || br_neg;
                acc_we     = b2_fire && (br_pos || br_neg);
            end
            cst_pkg::CMD_RDCLR: begin
                res.grad_total = b2_item_reg.in_range ? acc : 32'sd0;
                acc_we         = b2_fire && b2_item_reg.in_range;
                acc_wval       = 32'sd0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (thr_we) begin
            thr_mem[waddr] <= x;
        end
        if (rd_en) begin
            thr_rd_reg <= thr_mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (acc_we) begin
            acc_mem[waddr] <= acc_wval;
        end
        if (rd_en) begin
            acc_rd_reg <= acc_mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_vld_reg <= '0;
        end else if (acc_we) begin
            acc_vld_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            b2_item_reg     <= in_item;
            acc_vld_rd_reg  <= acc_vld_reg[raddr];
            thr_fwd_reg     <= thr_we && (b2_item_reg.chan == in_item.chan);
            thr_fwd_val_reg <= x;
            acc_fwd_reg     <= acc_we && (b2_item_reg.chan == in_item.chan);
            acc_fwd_val_reg <= acc_wval;
        end
        if (b2_fire) begin
            out_res_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                b2_valid_reg <= in_valid;
            end
            if (out_free) begin
                out_valid_reg <= b2_fire;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule
`default_nettype wire

@@ hw/rtl/channel_soft_threshold.sv @@
// Channel   Dir  Handshake                   Carries
// s_        in   s_tvalid / s_tready         request: kind in tuser, operands in tdata
// m_        out  m_tvalid / m_tready         result fields in tdata
// cfg_      in   cfg_wr_en (no handshake)    plane_size (index 0), channel_count (index 1)
//
// Throughput is one request per cycle unless m_ stalls; the threshold and accumulator
// memories are read as a request enters the execute stage and written as it leaves it,
// with a forward path for back-to-back requests on the same channel.
// An accepted request passes the queue, execute stage and output register to m_tvalid.
// Reset is synchronous on aresetn low; accumulator entries clear at once
// through per-entry valid bits, so there is no clearing pass.
// A stall on m_ fills the output register, execute stage and request queue
// before s_tready drops; the front stalls on its own only when the queue is full.
`default_nettype none
module channel_soft_threshold #(
    parameter int MAX_CHANNELS = cst_pkg::MAX_CHANNELS_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // Configuration write port
    input  wire logic                       cfg_wr_en,
    input  wire logic                       cfg_index,
    input  wire logic [cst_pkg::CFG_W-1:0]  cfg_wdata,
    // Request stream
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // [0] restart, [8:1] channel_sel, [24:9] data_in, [40:25] up_grad, [47:41] zero
    input  wire logic [47:0]                s_tdata,
    // [1:0] cmd
    input  wire logic [1:0]                 s_tuser,
    // Result stream
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // [15:0] result, [16] active, [48:17] grad_total, [56:49] channel_out, [63:57] zero
    output logic [63:0]                     m_tdata
);

    logic            fq_valid, fq_ready;
    cst_pkg::item_t  fq_item;
    logic            qb_valid, qb_ready;
    cst_pkg::item_t  qb_item;
    cst_pkg::res_t   res;

    // Front: track the channel walk and classify each request.
    cst_front #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (s_tuser),
        .in_restart (s_tdata[0]),
        .in_sel     (s_tdata[8:1]),
        .in_x       (s_tdata[24:9]),
        .in_g       (s_tdata[40:25]),
        .out_valid  (fq_valid),
        .out_ready  (fq_ready),
        .out_item   (fq_item)
    );

    // Queue: decouple the front from back-end stalls.
    cst_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_item  (fq_item),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_item   (qb_item)
    );

    // Back: read tables, shrink, accumulate, hold the result.
    cst_back #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (qb_valid),
        .in_ready  (qb_ready),
        .in_item   (qb_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    // Pack result fields, lowest field first.
    assign m_tdata = {7'd0, res.channel_out, res.grad_total, res.active, res.result};

endmodule
`default_nettype wire

@@ tb/sv/tb_channel_soft_threshold.sv @@
`default_nettype none

// One result as the block delivers it, unpacked from m_tdata.
typedef struct packed {
    logic signed [15:0] value;
    logic               active;
    logic signed [31:0] total;
    logic [7:0]         chan;
} shrink_out_t;

// Shadow copy of the block: threshold table, gradient sums, channel walk and
// the two walk registers. Requests are noted when accepted; results are
// checked in order against what the shadow copy worked out.
class shrink_scoreboard;
    logic signed [15:0] thresh [256];
    bit                 loaded [256];
    int                 accum  [256];
    int unsigned        plane_raw;
    int unsigned        count_raw;
    int unsigned        pos;
    int unsigned        chan;
    shrink_out_t        expected_q [$];
    int                 errors;

    function new();
        plane_raw = 1;
        count_raw = 1;
        pos       = 0;
        chan      = 0;
        errors    = 0;
        for (int i = 0; i < 256; i++) begin
            thresh[i] = '0;
            loaded[i] = 0;
            accum[i]  = 0;
        end
    endfunction

    function void write_reg(logic idx, int unsigned value);
        if (idx == cst_pkg::REG_PLANE_SIZE) begin
            plane_raw = value & 32'h1FFFF;
        end else begin
            count_raw = value & 32'h1FF;
        end
    endfunction

    function int unsigned plane_eff();
        if (plane_raw == 0) return 1;
        if (plane_raw > 65536) return 65536;
        return plane_raw;
    endfunction

    function int unsigned count_eff();
        if (count_raw == 0) return 1;
        if (count_raw > 256) return 256;
        return count_raw;
    endfunction

    // Channel the next element lands on.
    function int unsigned walk_channel(bit restart);
        return restart ? 0 : chan;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function int clip16(int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function int clip32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return int'(v);
    endfunction

    function void note_request(logic [1:0] cmd, bit restart, logic [7:0] sel,
                               logic signed [15:0] x, logic signed [15:0] g);
        shrink_out_t want;
        int          xi;
        int          ti;
        int          side;
        want  = '0;
        want.chan = sel;
        xi    = x;
        side  = 0;
        if (cmd == cst_pkg::CMD_LOAD) begin
            thresh[sel] = x;
            loaded[sel] = 1;
        end else if (cmd == cst_pkg::CMD_RDCLR) begin
            want.total = accum[sel];
            accum[sel] = 0;
        end else begin
            if (restart) begin
                pos  = 0;
                chan = 0;
            end
            want.chan = chan[7:0];
            ti = thresh[chan];
            // Upper test first, so a negative threshold leans to the upper side.
            if (xi > ti) side = 1;
            else if (xi < -ti) side = 2;
            want.active = (side != 0);
            if (cmd == cst_pkg::CMD_FWD) begin
                if (side == 1) want.value = 16'(clip16(xi - ti));
                else if (side == 2) want.value = 16'(clip16(xi + ti));
            end else begin
                if (side != 0) want.value = g;
                if (side == 1) accum[chan] = clip32(longint'(accum[chan]) - longint'(g));
                else if (side == 2) accum[chan] = clip32(longint'(accum[chan]) + longint'(g));
            end
            // Advance the walk against the registers as they stand now.
            if (pos + 1 >= plane_eff()) begin
                pos  = 0;
                chan = (chan + 1 >= count_eff()) ? 0 : chan + 1;
            end else begin
                pos = pos + 1;
            end
        end
        expected_q.push_back(want);
    endfunction

    task report(string msg);
        // Cap the log; the count keeps going.
        if (errors < 100) $display("mismatch: %s", msg);
        errors++;
    endtask

    task check_result(logic [63:0] data);
        shrink_out_t got;
        shrink_out_t want;
        got.value  = data[15:0];
        got.active = data[16];
        got.total  = data[48:17];
        got.chan   = data[56:49];
        if (expected_q.size() == 0) begin
            report($sformatf("result with nothing pending, tdata %h", data));
            return;
        end
        want = expected_q.pop_front();
        if (got.value !== want.value)
            report($sformatf("result %0d, want %0d", got.value, want.value));
        if (got.active !== want.active)
            report($sformatf("active %0b, want %0b", got.active, want.active));
        if (got.total !== want.total)
            report($sformatf("grad_total %0d, want %0d", got.total, want.total));
        if (got.chan !== want.chan)
            report($sformatf("channel_out %0d, want %0d", got.chan, want.chan));
    endtask
endclass

module tb_channel_soft_threshold;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 300;   // long output stall for back-pressure
    localparam int STUCK_LIMIT = 3000;  // cycles without progress before giving up

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [16:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;

    shrink_scoreboard sb;

    // Flow control shared between the two sides.
    bit hold_req;    // ask the result side for one long stall
    bit hold_off;    // result side is stalling now; keep the request side busy
    int tx_count;
    int stuck_cycles;

    channel_soft_threshold uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Offer one request, hold it until accepted, then note it in the shadow copy.
    task automatic send(logic [1:0] cmd, bit restart, logic [7:0] sel,
                        logic signed [15:0] x, logic signed [15:0] g);
        static bit tx_burst = 0;
        int gap;
        // Re-draw the pacing mode now and then so that gap-free stretches occur.
        if (tx_count % 32 == 0) tx_burst = ($urandom_range(0, 3) == 0);
        tx_count++;
        gap = (tx_burst || hold_off) ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'd0, g, x, sel, restart};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(cmd, restart, sel, x, g);
    endtask

    // Drop the request side and wait until every pending result has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // Write both walk registers on back-to-back edges; the block is idle here.
    task automatic program_walk(int unsigned plane, int unsigned count);
        cfg_wr_en <= 1'b1;
        cfg_index <= cst_pkg::REG_PLANE_SIZE;
        cfg_wdata <= plane[16:0];
        @(posedge aclk);
        sb.write_reg(cst_pkg::REG_PLANE_SIZE, plane);
        cfg_index <= cst_pkg::REG_CHANNEL_COUNT;
        cfg_wdata <= count[16:0];
        @(posedge aclk);
        sb.write_reg(cst_pkg::REG_CHANNEL_COUNT, count);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic signed [15:0] pick_threshold();
        case ($urandom_range(0, 7))
            0: return 16'($urandom);
            1, 2: return 16'($urandom_range(0, 16'h0400));
            3: return 16'sd0;
            4: return 16'sh7FFF;
            5: return 16'sh8000;
            6: return -16'($urandom_range(0, 16'h0400));
            default: return 16'($urandom_range(0, 16'h2000));
        endcase
    endfunction

    // Element values cluster on the decision edges of the channel's threshold.
    function automatic logic signed [15:0] pick_element(logic signed [15:0] t);
        case ($urandom_range(0, 7))
            0: return 16'($urandom);
            1: return t;
            2: return -t;
            3: return t + 16'sd1;
            4: return -t - 16'sd1;
            5: return 16'sh7FFF;
            6: return 16'sh8000;
            default: return 16'($signed($urandom_range(0, 1023)) - 512);
        endcase
    endfunction

    function automatic logic signed [15:0] pick_grad();
        case ($urandom_range(0, 7))
            6: return 16'sh7FFF;
            7: return 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Random mix of loads, reads and elements. restart_div of 0 never restarts
    // the walk, so long phases get all the way round the channel ring.
    task automatic run_random(int n, int restart_div);
        int          pick;
        bit          restart;
        logic [1:0]  cmd;
        int unsigned ch;
        logic [7:0]  sel;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 9);
            cmd  = (pick == 0) ? cst_pkg::CMD_LOAD : (pick == 1) ? cst_pkg::CMD_RDCLR :
                   (pick <= 5) ? cst_pkg::CMD_FWD : cst_pkg::CMD_BWD;
            if (cmd == cst_pkg::CMD_LOAD) begin
                send(cst_pkg::CMD_LOAD, 1'($urandom), 8'($urandom), pick_threshold(),
                     16'($urandom));
            end else if (cmd == cst_pkg::CMD_RDCLR) begin
                // Half the reads hit a channel the walk is using.
                sel = $urandom_range(0, 1) ? 8'($urandom_range(0, sb.count_eff() - 1))
                                           : 8'($urandom);
                send(cst_pkg::CMD_RDCLR, 1'($urandom), sel, 16'($urandom), 16'($urandom));
            end else begin
                restart = (restart_div != 0) && ($urandom_range(0, restart_div - 1) == 0);
                ch = sb.walk_channel(restart);
                // Never let an element read a threshold that was not loaded.
                if (!sb.loaded[ch])
                    send(cst_pkg::CMD_LOAD, 1'($urandom), 8'(ch), pick_threshold(),
                         16'($urandom));
                send(cmd, restart, 8'(ch), pick_element(sb.thresh[ch]), pick_grad());
            end
        end
    endtask

    // Result side: random stalls, one long hold on request, check in order.
    initial begin : result_side
        bit rx_burst;
        int gap;
        int rx_count;
        rx_burst = 0;
        rx_count = 0;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_count % 32 == 0) rx_burst = ($urandom_range(0, 3) == 0);
            rx_count++;
            gap = rx_burst ? 0 : $urandom_range(0, 16);
            if (hold_req) begin
                // Stall long enough to fill every stage and push back on s_tready.
                hold_req = 0;
                hold_off = 1;
                gap = HOLD_CYCLES;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            hold_off = 0;
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tdata);
        end
    end

    // Watchdog: count cycles with work outstanding but no transfer on either side.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (!s_tvalid && sb.pending() == 0)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin : request_side
        int unsigned plane_list [8];
        int unsigned count_list [8];
        int          item_list  [8];
        int          restart_list [8];

        plane_list   = '{5, 0, 3, 65536, 131071, 2, 1, 7};
        count_list   = '{1, 0, 4, 256, 511, 256, 40, 3};
        item_list    = '{30, 25, 45, 15, 15, 40, 150, 30};
        restart_list = '{8, 8, 8, 8, 8, 16, 0, 8};

        sb = new();
        hold_req  = 0;
        hold_off  = 0;
        tx_count  = 0;
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= cst_pkg::REG_PLANE_SIZE;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= cst_pkg::CMD_LOAD;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, walk at its reset values (one element per plane, one channel).
        // Restart on a load is ignored.
        send(cst_pkg::CMD_LOAD, 1'b1, 8'd0, 16'sh0100, 16'sh7FFF);
        send(cst_pkg::CMD_FWD, 1'b0, 8'd0, 16'sh7FFF, 16'sd0);
        send(cst_pkg::CMD_FWD, 1'b0, 8'd0, 16'sh8000, 16'sd0);
        // Exactly on the threshold in either direction stays inactive.
        send(cst_pkg::CMD_FWD, 1'b0, 8'd0, 16'sh0100, 16'sd0);
        send(cst_pkg::CMD_FWD, 1'b0, 8'd0, -16'sh0100, 16'sd0);
        send(cst_pkg::CMD_FWD, 1'b0, 8'd0, 16'sh0101, 16'sd0);
        send(cst_pkg::CMD_BWD, 1'b0, 8'd0, 16'sh0200, 16'sh8000);
        send(cst_pkg::CMD_BWD, 1'b0, 8'd0, -16'sh0200, 16'sh7FFF);
        send(cst_pkg::CMD_BWD, 1'b0, 8'd0, 16'sd0, 16'sh1234);
        // Read-clear twice: the sum, then zero. Restart ignored on a read.
        send(cst_pkg::CMD_RDCLR, 1'b1, 8'd0, 16'sh7FFF, 16'sh7FFF);
        send(cst_pkg::CMD_RDCLR, 1'b0, 8'd0, 16'sd0, 16'sd0);
        send(cst_pkg::CMD_LOAD, 1'b0, 8'd255, 16'sh8000, 16'sd0);
        send(cst_pkg::CMD_LOAD, 1'b0, 8'd5, 16'sh7FFF, 16'sd0);
        send(cst_pkg::CMD_RDCLR, 1'b0, 8'd255, 16'sd0, 16'sd0);
        // Negative threshold: both saturating ends of the forward path.
        send(cst_pkg::CMD_LOAD, 1'b0, 8'd0, 16'sh8000, 16'sd0);
        send(cst_pkg::CMD_FWD, 1'b0, 8'd0, 16'sh7FFF, 16'sd0);
        send(cst_pkg::CMD_FWD, 1'b0, 8'd0, 16'sh8000, 16'sd0);
        send(cst_pkg::CMD_LOAD, 1'b0, 8'd0, -16'sd5, 16'sd0);
        send(cst_pkg::CMD_FWD, 1'b0, 8'd0, -16'sd6, 16'sd0);
        send(cst_pkg::CMD_FWD, 1'b0, 8'd0, 16'sd0, 16'sd0);
        send(cst_pkg::CMD_LOAD, 1'b0, 8'd0, 16'sd0, 16'sd0);
        send(cst_pkg::CMD_FWD, 1'b0, 8'd0, 16'sd0, 16'sd0);
        send(cst_pkg::CMD_BWD, 1'b1, 8'd0, -16'sd1, 16'sh8000);
        send(cst_pkg::CMD_LOAD, 1'b0, 8'd0, 16'sh7FFF, 16'sd0);
        send(cst_pkg::CMD_FWD, 1'b0, 8'd0, 16'sh7FFF, 16'sd0);
        drain();

        // Random phases, each under its own walk setting, out-of-range ones included.
        for (int p = 0; p < 8; p++) begin
            drain();
            program_walk(plane_list[p], count_list[p]);
            if (p == 0 || p == 6) hold_req = 1;
            run_random(item_list[p], restart_list[p]);
        end

        drain();
        repeat (12) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
